/* rtl/dshc_pkg.sv */
`default_nettype none
package dshc_pkg;

    // opcodes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // code layout and special values
    localparam int          MAG_W      = 13;
    localparam logic [15:0] CODE_ERROR = 16'hFFFF;
    localparam logic [1:0]  K_MAX      = 2'd3;
    localparam logic [31:0] QNAN_BITS  = 32'h7FC00000;
    localparam logic [MAG_W-1:0] MAG_LIMIT = 13'h1FFF;

    // |x| at or above this pattern (8191.0f) or NaN encodes as error
    localparam logic [30:0] ENC_LIMIT_BITS = 31'h45FFF800;

    // long division of the normalized magnitude by 5^k
    localparam int DIV_FRAC   = 22;
    localparam int DIV_W      = MAG_W + DIV_FRAC;
    localparam int DIV_STEPS  = 7;
    localparam int DIV_STAGES = DIV_W / DIV_STEPS;
    localparam int REM_W      = 7;

    // decode operand carried through the divider
    typedef struct packed {
        logic             sg;
        logic             err;
        logic             zero;
        logic [3:0]       nsh;
        logic [1:0]       k;
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] w;
    } t_div;

    // 5^k for the divider
    function automatic logic [REM_W-1:0] pow5(input logic [1:0] k);
        logic [REM_W-1:0] v;
        case (k)
            2'd0:    v = 7'd1;
            2'd1:    v = 7'd5;
            2'd2:    v = 7'd25;
            2'd3:    v = 7'd125;
            default: v = 7'd1;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/dshc_enc.sv */
`default_nettype none
module dshc_enc (
    input  wire logic        i_clk,
    input  wire logic [2:0]  i_en,
    input  wire logic [31:0] i_bits,
    output logic      [15:0] o_code
);
    import dshc_pkg::*;

    localparam logic [7:0] EB_TINY = 8'd116;
    localparam logic [7:0] EB_BASE = 8'd150;

    // round a product to 24 significant bits, nearest even, dropping dsh bits
    function automatic logic [24:0] rnd24(input logic [33:0] x, input logic [5:0] dsh);
        logic [33:0] base;
        logic [33:0] mask;
        logic        g;
        logic        st;
        base = x >> dsh;
        mask = (34'd1 << (dsh - 6'd1)) - 34'd1;
        g    = x[dsh - 6'd1];
        st   = |(x & mask);
        return base[24:0] + {24'd0, g & (st | base[0])};
    endfunction

    logic [30:0] absb;
    logic        n_neg;
    logic [23:0] n_m;

    // stage 0: flags and products by 10, 100, 1000
    logic        r_neg0, r_err0, r_tiny0;
    logic [5:0]  r_shb0;
    logic [23:0] r_m0;
    logic [33:0] r_x1, r_x2, r_x3;

    assign absb  = i_bits[30:0];
    assign n_neg = i_bits[31] & (absb != 31'd0);
    assign n_m   = {1'b1, i_bits[22:0]};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg0  <= n_neg;
            r_err0  <= (absb >= ENC_LIMIT_BITS);
            r_tiny0 <= (i_bits[30:23] < EB_TINY);
            r_shb0  <= 6'(EB_BASE - i_bits[30:23]);
            r_m0    <= n_m;
            r_x1    <= 34'(n_m) * 34'd10;
            r_x2    <= 34'(n_m) * 34'd100;
            r_x3    <= 34'(n_m) * 34'd1000;
        end
    end

    // stage 1: round each product and work out its integer shift
    logic [5:0]  d1, d2, d3;
    logic        r_neg1, r_err1, r_tiny1;
    logic [24:0] r_r0, r_r1, r_r2, r_r3;
    logic [5:0]  r_sh0, r_sh1, r_sh2, r_sh3;

    assign d1 = r_x1[27] ? 6'd4  : 6'd3;
    assign d2 = r_x2[30] ? 6'd7  : 6'd6;
    assign d3 = r_x3[33] ? 6'd10 : 6'd9;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_neg1  <= r_neg0;
            r_err1  <= r_err0;
            r_tiny1 <= r_tiny0;
            r_r0    <= {1'b0, r_m0};
            r_r1    <= rnd24(r_x1, d1);
            r_r2    <= rnd24(r_x2, d2);
            r_r3    <= rnd24(r_x3, d3);
            r_sh0   <= r_shb0;
            r_sh1   <= r_shb0 - d1;
            r_sh2   <= r_shb0 - d2;
            r_sh3   <= r_shb0 - d3;
        end
    end

    // stage 2: truncate, pick the largest fitting scale, pack
    logic [24:0] f0, f1, f2, f3;
    logic [1:0]  n_k;
    logic [24:0] n_f;
    logic [15:0] n_code;
    logic [15:0] r_code;

    assign f0 = r_r0 >> r_sh0;
    assign f1 = r_r1 >> r_sh1;
    assign f2 = r_r2 >> r_sh2;
    assign f3 = r_r3 >> r_sh3;

    always_comb begin
        if (f3 < 25'(MAG_LIMIT)) begin
            n_k = 2'd3;
            n_f = f3;
        end else if (f2 < 25'(MAG_LIMIT)) begin
            n_k = 2'd2;
            n_f = f2;
        end else if (f1 < 25'(MAG_LIMIT)) begin
            n_k = 2'd1;
            n_f = f1;
        end else begin
            n_k = 2'd0;
            n_f = f0;
        end
        if (r_err1) begin
            n_code = CODE_ERROR;
        end else if (r_tiny1) begin
            n_code = {r_neg1, 13'd0, K_MAX};
        end else begin
            n_code = {r_neg1, n_f[MAG_W-1:0], n_k};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_code <= n_code;
        end
    end

    assign o_code = r_code;
endmodule
`default_nettype wire

/* rtl/dshc_dec_front.sv */
`default_nettype none
module dshc_dec_front (
    input  wire logic [15:0]  i_code,
    output dshc_pkg::t_div    o_div
);
    import dshc_pkg::*;

    logic [MAG_W-1:0] m;
    logic [3:0]       msb;
    logic [3:0]       nsh;

    assign m = i_code[14:2];

    // leading one of the magnitude
    always_comb begin
        msb = 4'd0;
        for (int i = 0; i < MAG_W; i++) begin
            if (m[i]) begin
                msb = 4'(i);
            end
        end
    end

    assign nsh = 4'(MAG_W - 1) - msb;

    always_comb begin
        o_div.sg   = i_code[15];
        o_div.err  = (i_code == CODE_ERROR);
        o_div.zero = (m == '0);
        o_div.nsh  = nsh;
        o_div.k    = i_code[1:0];
        o_div.rem  = '0;
        o_div.w    = {m << nsh, {DIV_FRAC{1'b0}}};
    end
endmodule
`default_nettype wire

/* rtl/dshc_div_stage.sv */
`default_nettype none
module dshc_div_stage (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire dshc_pkg::t_div i_div,
    output dshc_pkg::t_div      o_div
);
    import dshc_pkg::*;

    t_div             n_div;
    t_div             r_div;
    logic [REM_W-1:0] dv;
    logic [REM_W:0]   t;

    assign dv = pow5(i_div.k);

    // restoring long division, one quotient bit per step
    always_comb begin
        n_div = i_div;
        t     = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
            t       = {n_div.rem, n_div.w[DIV_W-1]};
            n_div.w = {n_div.w[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, dv}) begin
                t          = t - {1'b0, dv};
                n_div.w[0] = 1'b1;
            end
            n_div.rem = t[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;
endmodule
`default_nettype wire

/* rtl/dshc_dec_back.sv */
`default_nettype none
module dshc_dec_back (
    input  wire dshc_pkg::t_div i_div,
    output logic [31:0]         o_bits
);
    import dshc_pkg::*;

    logic [2:0]       lead;
    logic [DIV_W-1:0] qn;
    logic [23:0]      sig;
    logic             g;
    logic             st;
    logic [24:0]      sum;
    logic [7:0]       ex;
    logic [22:0]      frac;

    // quotient leads somewhere in its top eight bits
    always_comb begin
        lead = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (i_div.w[DIV_W-8+i]) begin
                lead = 3'(i);
            end
        end
    end

    assign qn  = i_div.w << (3'd7 - lead);
    assign sig = qn[DIV_W-1 -: 24];
    assign g   = qn[DIV_W-25];
    assign st  = (|qn[DIV_W-26:0]) | (i_div.rem != '0);
    assign sum = {1'b0, sig} + {24'd0, g & (st | sig[0])};

    // biased exponent: lead position less fraction bits, shift and k, plus the rounding carry
    assign ex = 8'(DIV_W - 8 + 127 - DIV_FRAC) + {5'd0, lead} - {4'd0, i_div.nsh}
              - {6'd0, i_div.k} + {7'd0, sum[24]};
    assign frac = sum[24] ? 23'd0 : sum[22:0];

    always_comb begin
        if (i_div.err) begin
            o_bits = QNAN_BITS;
        end else if (i_div.zero) begin
            o_bits = {i_div.sg, 31'd0};
        end else begin
            o_bits = {i_div.sg, ex, frac};
        end
    end
endmodule
`default_nettype wire

/* rtl/decimal_scaled_half_codec_unit.sv */
`default_nettype none
// channel   valid        ready        payload
// input     i_in_valid   o_in_ready   i_opcode, i_operand
// output    o_out_valid  i_out_ready  o_result_value
//
// seven register stages, which every transaction passes through in order,
// and one transaction can be taken every cycle while no stall backs up to the input
// the depth is set by the decode divider: five stages of seven quotient bits each
// reset (synchronous, active low) clears the stage valid bits only
// each stage advances when it is empty or the stage after it advances, so stalls
// close bubbles and never drop or repeat a transaction
module decimal_scaled_half_codec_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_opcode,
    input  wire logic [31:0] i_operand,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [31:0] o_result_value
);
    import dshc_pkg::*;

    localparam int NSTG = DIV_STAGES + 2;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    logic [NSTG-2:0] r_op;
    logic [15:0]     enc_code;
    logic [15:0]     r_code [3:NSTG-2];
    t_div            dec_in;
    t_div            r_div0;
    t_div            div_q [0:DIV_STAGES];
    logic [31:0]     dec_bits;
    logic [31:0]     r_res;

    // stage advance chain, back to front
    always_comb begin
        en[NSTG-1] = ~r_vld[NSTG-1] | i_out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = ~r_vld[i] | en[i+1];
        end
    end

    assign o_in_ready = en[0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // opcode and encode result carried alongside the divider
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_op[0] <= i_opcode;
        end
        for (int i = 1; i < NSTG - 1; i++) begin
            if (en[i]) begin
                r_op[i] <= r_op[i-1];
            end
        end
        if (en[3]) begin
            r_code[3] <= enc_code;
        end
        for (int i = 4; i < NSTG - 1; i++) begin
            if (en[i]) begin
                r_code[i] <= r_code[i-1];
            end
        end
    end

    // encode path, stages 0 to 2
    dshc_enc u_enc (
        .i_clk  (i_clk),
        .i_en   (en[2:0]),
        .i_bits (i_operand),
        .o_code (enc_code)
    );

    // decode path: prepare, divide, round
    dshc_dec_front u_front (
        .i_code (i_operand[15:0]),
        .o_div  (dec_in)
    );

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_div0 <= dec_in;
        end
    end

    assign div_q[0] = r_div0;

    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        dshc_div_stage u_stage (
            .i_clk (i_clk),
            .i_en  (en[g]),
            .i_div (div_q[g-1]),
            .o_div (div_q[g])
        );
    end

    dshc_dec_back u_back (
        .i_div  (div_q[DIV_STAGES]),
        .o_bits (dec_bits)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            r_res <= (r_op[NSTG-2] == OP_DECODE) ? dec_bits : {16'd0, r_code[NSTG-2]};
        end
    end

    assign o_out_valid    = r_vld[NSTG-1];
    assign o_result_value = r_res;
endmodule
`default_nettype wire
